FILE: rtl/core/kmp_pkg.sv
// Shared request mode codes and controller/datapath interface types for the KMP matcher.
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    localparam logic [1:0] MODE_NEW     = 2'd0;
    localparam logic [1:0] MODE_APPEND  = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    typedef struct packed {
        logic load;    // request accepted this cycle
        logic search;  // a request is in work
        logic commit;  // update state and write the result register
    } kmp_cmd_t;

    typedef struct packed {
        logic done;    // fallback walk has settled
    } kmp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/kmp_stream_matcher_top.sv
// Top level of the KMP stream matcher: controller and datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_mode[1:0], s_data_byte[7:0]
//  m_      | out       | m_valid / m_ready  | m_match_found, m_match_start[31:0],
//          |           |                    | m_match_total[31:0], m_pattern_truncated
//
// Sequence: a request is accepted, then compared, with one failure-table fallback step per
// cycle until it settles, and committed; the walk is set by the registered read of the
// pattern and failure stores.
// s_ready is high only between requests; one request is in work at a time.
// A result waits in the output register until taken; the next request is accepted and
// walked meanwhile, and its commit waits until the output register is free.
// Reset (aresetn low, synchronous) clears lengths, offset, count and flags; the stores
// need no clearing since only written entries are ever used.
`timescale 1ns / 1ps
`default_nettype none

module kmp_stream_matcher_top
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_match_found,
    output logic [31:0]      m_match_start,
    output logic [31:0]      m_match_total,
    output logic             m_pattern_truncated
);

    kmp_cmd_t    cmd;
    kmp_status_t status;

    // sequencing: accept, walk, commit when the result slot frees
    kmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // stores, fallback walk over the failure table, counters and result register
    kmp_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_mode              (s_mode),
        .s_data_byte         (s_data_byte),
        .m_match_found       (m_match_found),
        .m_match_start       (m_match_start),
        .m_match_total       (m_match_total),
        .m_pattern_truncated (m_pattern_truncated)
    );

endmodule

`default_nettype wire

FILE: rtl/core/kmp_ctrl.sv
// Controller state machine for the KMP matcher: request sequencing and result valid.
`timescale 1ns / 1ps
`default_nettype none

module kmp_ctrl
    import kmp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output kmp_cmd_t         cmd,
    input  wire kmp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        cmd.load   = s_valid && s_ready;
        cmd.search = (state_reg == ST_SEARCH);
        cmd.commit = cmd.search && status.done && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (cmd.commit) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result held until taken; a commit only happens once the slot is free
    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/kmp_dp.sv
// Datapath for the KMP matcher: pattern and failure stores, fallback walk, counters, result.
`timescale 1ns / 1ps
`default_nettype none

module kmp_dp
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire kmp_cmd_t   cmd,
    output kmp_status_t     status,
    input  wire logic [1:0] s_mode,
    input  wire logic [7:0] s_data_byte,
    output logic            m_match_found,
    output logic [31:0]     m_match_start,
    output logic [31:0]     m_match_total,
    output logic            m_pattern_truncated
);

    localparam int IW   = $clog2(PATTERN_MAX);
    localparam int LW   = $clog2(PATTERN_MAX + 1);
    localparam int WIDE = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
    localparam logic [LW-1:0] PMAX_L = LW'(PATTERN_MAX);

    // stores
    logic [7:0]    pat_mem  [PATTERN_MAX];
    logic [IW-1:0] fail_mem [PATTERN_MAX];
    logic [7:0]    pat_rd;
    logic [IW-1:0] fail_rd;

    // request and walk registers
    logic [1:0]    mode_reg;
    logic [7:0]    byte_reg;
    logic [IW-1:0] j_reg;

    // matcher state
    logic [LW-1:0]          plen_reg, plen_next;
    logic [IW-1:0]          pre_reg, pre_next;
    logic [IW-1:0]          matched_reg, matched_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [31:0]            count_reg, count_next;
    logic                   trunc_reg, trunc_next;
    logic                   found_next;
    logic [OFFSET_BITS-1:0] start_next;
    logic [WIDE-1:0]        start_wide;

    logic [IW-1:0] j_src, j0, rd_idx, fail_idx, wr_idx, wr_fail;
    logic [LW-1:0] j_plus, j_final;
    logic          loop_active, hit, step, is_new, is_append, is_text, wr_en;

    // starting index for the walk, clamped to a valid prefix length
    always_comb begin
        j_src = (s_mode == MODE_TEXT) ? matched_reg : pre_reg;
        j0    = (LW'(j_src) >= plen_reg) ? '0 : j_src;
    end

    always_comb begin
        is_new      = (mode_reg == MODE_NEW);
        is_append   = (mode_reg == MODE_APPEND);
        is_text     = (mode_reg == MODE_TEXT);
        loop_active = (is_text && plen_reg != '0) ||
                      (is_append && plen_reg != '0 && plen_reg != PMAX_L);
        hit         = (pat_rd == byte_reg);
        j_plus      = LW'(j_reg) + LW'(1);
        j_final     = (loop_active && hit) ? j_plus : '0;
        status.done = !loop_active || hit || (j_reg == '0);
        step        = cmd.search && !status.done;
    end

    // read address: start index on load, failure link on a fallback, else hold
    always_comb begin
        priority if (cmd.load) begin
            rd_idx = j0;
        end else if (step) begin
            rd_idx = fail_rd;
        end else begin
            rd_idx = j_reg;
        end
        fail_idx = (rd_idx == '0) ? '0 : rd_idx - IW'(1);
    end

    always_comb begin
        wr_en   = cmd.commit && (is_new || (is_append && plen_reg != PMAX_L));
        wr_idx  = is_new ? '0 : plen_reg[IW-1:0];
        wr_fail = (is_new || plen_reg == '0) ? '0 : j_final[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        pat_rd  <= pat_mem[rd_idx];
        fail_rd <= fail_mem[fail_idx];
        if (wr_en) begin
            pat_mem[wr_idx]  <= byte_reg;
            fail_mem[wr_idx] <= wr_fail;
        end
    end

    always_comb begin
        plen_next    = plen_reg;
        pre_next     = pre_reg;
        matched_next = matched_reg;
        offset_next  = offset_reg;
        count_next   = count_reg;
        trunc_next   = trunc_reg;
        found_next   = 1'b0;
        start_next   = '0;
        unique case (mode_reg)
            MODE_NEW: begin
                plen_next    = LW'(1);
                pre_next     = '0;
                matched_next = '0;
                trunc_next   = 1'b0;
            end
            MODE_APPEND: begin
                if (plen_reg == PMAX_L) begin
                    trunc_next = 1'b1;
                end else begin
                    pre_next  = wr_fail;
                    plen_next = plen_reg + LW'(1);
                end
            end
            MODE_TEXT: begin
                offset_next = offset_reg + OFFSET_BITS'(1);
                if (plen_reg != '0) begin
                    if (j_final == plen_reg) begin
                        found_next   = 1'b1;
                        start_next   = offset_reg + OFFSET_BITS'(1) - OFFSET_BITS'(plen_reg);
                        // failure entry of the last pattern byte equals pre_reg
                        matched_next = pre_reg;
                        if (count_reg != '1) count_next = count_reg + 32'd1;
                    end else begin
                        matched_next = j_final[IW-1:0];
                    end
                end
            end
            MODE_RESTART: begin
                offset_next  = '0;
                count_next   = '0;
                matched_next = '0;
            end
        endcase
        start_wide = WIDE'(start_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg    <= '0;
            pre_reg     <= '0;
            matched_reg <= '0;
            offset_reg  <= '0;
            count_reg   <= '0;
            trunc_reg   <= 1'b0;
        end else if (cmd.commit) begin
            plen_reg    <= plen_next;
            pre_reg     <= pre_next;
            matched_reg <= matched_next;
            offset_reg  <= offset_next;
            count_reg   <= count_next;
            trunc_reg   <= trunc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            byte_reg <= s_data_byte;
        end
        if (cmd.load) begin
            j_reg <= j0;
        end else if (step) begin
            j_reg <= fail_rd;
        end
        if (cmd.commit) begin
            m_match_found       <= found_next;
            m_match_start       <= start_wide[31:0];
            m_match_total       <= count_next;
            m_pattern_truncated <= trunc_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/kmp_checker.sv
// Port-level assertions for the KMP stream matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kmp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_mode,
    input wire logic [7:0]  s_data_byte,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_match_found,
    input wire logic [31:0] m_match_start,
    input wire logic [31:0] m_match_total,
    input wire logic        m_pattern_truncated
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one request in work at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready held after accept");

    // start offset is zero unless a match is flagged
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_match_found) |-> (m_match_start == 32'd0))
        else $error("start offset without a match");

    // a reported match is counted
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_match_found) |-> (m_match_total != 32'd0))
        else $error("match with zero total");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_match_total)
            && $stable(m_match_found) && $stable(m_match_start)
            && $stable(m_pattern_truncated)))
        else $error("stalled result changed");

endmodule

bind kmp_stream_matcher_top kmp_checker u_kmp_checker (.*);

`default_nettype wire
